@@ rtl/msb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_pkg - shared buffer stack package
// Sizes, slot pointer widths and the controller command bundle.
// ----------------------------------------------------------------------------
package msb_pkg;

   localparam int NUM_STACKS = 4;
   localparam int CAPACITY   = 16;

   // slot pointer holds CAPACITY as the null code
   localparam int SLOT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int STACK_W = 2;
   localparam int DATA_W  = 32;

   localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture an accepted request
      logic read;       // pick the slot, read link and data stores
      logic exec;       // update pointers and stores, load the response
   } msb_cmd_type;

endpackage
`default_nettype wire

@@ rtl/msb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_ctrl - sequencer
// Three-state controller: idle, read, execute. Owns the response valid flag.
// ----------------------------------------------------------------------------
module msb_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output msb_pkg::msb_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, accept, exec_fire;

   // response slot free this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec_fire = (state_ff == ST_EXEC) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || exec_fire;
   assign accept    = req_valid && req_ready;

   assign cmd.load_req = accept;
   assign cmd.read     = (state_ff == ST_READ);
   assign cmd.exec     = exec_fire;
   assign rsp_valid    = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_fire) state_in = accept ? ST_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on execute, cleared when taken
   always_comb begin
      if (exec_fire)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/msb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_datapath - stack pointers and slot stores
// Head pointers, free list head, fill count, link and data memories.
// ----------------------------------------------------------------------------
module msb_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  msb_pkg::msb_cmd_type                cmd,
   input  wire                                 req_type,
   input  wire [msb_pkg::STACK_W-1:0]          req_stack_index,
   input  wire signed [msb_pkg::DATA_W-1:0]    req_push_value,
   output logic                                rsp_success,
   output logic signed [msb_pkg::DATA_W-1:0]   rsp_popped_value
);

   localparam int SW = msb_pkg::SLOT_W;
   localparam int IW = msb_pkg::IDX_W;
   localparam int DW = msb_pkg::DATA_W;

   // stores
   logic [SW-1:0] link_mem [msb_pkg::CAPACITY];
   logic [DW-1:0] data_mem [msb_pkg::CAPACITY];

   // pointer state
   logic [SW-1:0] stack_head_ff [msb_pkg::NUM_STACKS];
   logic [SW-1:0] free_head_ff;
   logic [SW-1:0] fill_ff;        // slots at or above are untouched since reset

   // request and read-stage registers
   logic                          op_ff;
   logic [msb_pkg::STACK_W-1:0]   sidx_ff;
   logic [DW-1:0]                 value_ff;
   logic [SW-1:0]                 slot_ff, slot_in;
   logic [SW-1:0]                 link_rd_ff;
   logic [DW-1:0]                 data_rd_ff;
   logic [SW-1:0]                 head_cur_ff, head_cur_in;

   // response payload
   logic                          success_ff;
   logic [DW-1:0]                 popped_ff;

   logic          sidx_ok;
   logic [SW-1:0] link_eff;
   logic          slot_ok;
   logic          do_push, do_pop;

   assign sidx_ok = (32'(sidx_ff) < msb_pkg::NUM_STACKS);

   // slot under work: free head for push, stack top for pop
   always_comb begin
      head_cur_in = sidx_ok ? stack_head_ff[sidx_ff] : msb_pkg::NULL_SLOT;
      slot_in     = (op_ff == msb_pkg::OP_POP) ? head_cur_in : free_head_ff;
   end

   // untouched slot links implicitly to the next one (last gives null)
   assign link_eff = (slot_ff >= fill_ff) ? SW'(slot_ff + SW'(1)) : link_rd_ff;
   assign slot_ok  = sidx_ok && (slot_ff < msb_pkg::NULL_SLOT);
   assign do_push  = cmd.exec && slot_ok && (op_ff == msb_pkg::OP_PUSH);
   assign do_pop   = cmd.exec && slot_ok && (op_ff == msb_pkg::OP_POP);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_type;
         sidx_ff  <= req_stack_index;
         value_ff <= req_push_value;
      end
   end

   // read stage: registered store reads
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         slot_ff     <= slot_in;
         head_cur_ff <= head_cur_in;
         link_rd_ff  <= link_mem[slot_in[IW-1:0]];
         data_rd_ff  <= data_mem[slot_in[IW-1:0]];
      end
   end

   // store writes
   always_ff @(posedge clock) begin
      if (do_push) begin
         link_mem[slot_ff[IW-1:0]] <= head_cur_ff;
         data_mem[slot_ff[IW-1:0]] <= value_ff;
      end else if (do_pop) begin
         link_mem[slot_ff[IW-1:0]] <= free_head_ff;
      end
   end

   // pointer updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msb_pkg::NUM_STACKS; i++) begin
            stack_head_ff[i] <= msb_pkg::NULL_SLOT;
         end
         free_head_ff <= '0;
         fill_ff      <= '0;
      end else if (do_push) begin
         stack_head_ff[sidx_ff] <= slot_ff;
         free_head_ff           <= link_eff;
         if (slot_ff == fill_ff) fill_ff <= SW'(fill_ff + SW'(1));
      end else if (do_pop) begin
         stack_head_ff[sidx_ff] <= link_eff;
         free_head_ff           <= slot_ff;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         success_ff <= slot_ok;
         popped_ff  <= do_pop ? data_rd_ff : '0;
      end
   end

   assign rsp_success      = success_ff;
   assign rsp_popped_value = signed'(popped_ff);

endmodule
`default_nettype wire

@@ rtl/multi_stack_shared_buffer_unit.sv @@
`default_nettype none
// Flow: read state reads the head pointer then the link store; execute state
//   writes back and loads the response, waiting while the response slot is full.
//   The next request is accepted as the current one executes, not while reading.
// Reset: synchronous; all stacks empty, free list runs through every slot in
//   order (tracked by a fill count, no clearing pass), no response pending.
// ----------------------------------------------------------------------------
// multi_stack_shared_buffer_unit - several LIFO stacks in one slot store
// Push takes the free list head, pop returns the top slot to the free list.
// ----------------------------------------------------------------------------
module multi_stack_shared_buffer_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_type,
   input  wire [msb_pkg::STACK_W-1:0]          req_stack_index,
   input  wire signed [msb_pkg::DATA_W-1:0]    req_push_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_success,
   output logic signed [msb_pkg::DATA_W-1:0]   rsp_popped_value
);

   msb_pkg::msb_cmd_type cmd;

   // sequencer
   msb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // pointers and stores
   msb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_stack_index  (req_stack_index),
      .req_push_value   (req_push_value),
      .rsp_success      (rsp_success),
      .rsp_popped_value (rsp_popped_value)
   );

endmodule
`default_nettype wire

@@ tb/tb_multi_stack_shared_buffer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_buffer_unit - shared buffer stack regression
// Drives push and pop requests through the valid/ready request channel. A
// shadow copy of the free list, the stack heads and the slot store predicts
// each response. Both sides idle and stall at random. Responses are checked
// in order against the predicted queue.
// ----------------------------------------------------------------------------

typedef struct {
   logic                         ok;
   logic [msb_pkg::DATA_W-1:0]   value;
} stack_outcome_type;

// shadow of the slot store and its linked lists, plus the response queue
class shared_stack_predictor;
   logic [msb_pkg::DATA_W-1:0]   slot_value [msb_pkg::CAPACITY];
   logic [msb_pkg::SLOT_W-1:0]   slot_next  [msb_pkg::CAPACITY];
   logic [msb_pkg::SLOT_W-1:0]   top_slot   [msb_pkg::NUM_STACKS];
   logic [msb_pkg::SLOT_W-1:0]   free_head;
   stack_outcome_type            expected_outcomes [$];
   int unsigned                  mismatches;

   // state after reset: free list runs through every slot in order
   function new();
      for (int i = 0; i < msb_pkg::CAPACITY; i++) begin
         slot_value[i] = '0;
         slot_next[i]  = (i + 1 < msb_pkg::CAPACITY) ? msb_pkg::SLOT_W'(i + 1)
                                                     : msb_pkg::NULL_SLOT;
      end
      for (int i = 0; i < msb_pkg::NUM_STACKS; i++)
         top_slot[i] = msb_pkg::NULL_SLOT;
      free_head  = '0;
      mismatches = 0;
   endfunction

   function int unsigned pending();
      return expected_outcomes.size();
   endfunction

   // apply an accepted request to the shadow and queue its response
   function void note_request(logic op, logic [msb_pkg::STACK_W-1:0] idx,
                              logic [msb_pkg::DATA_W-1:0] val);
      stack_outcome_type          outcome;
      logic [msb_pkg::SLOT_W-1:0] slot;
      outcome.ok    = 1'b0;
      outcome.value = '0;
      if (int'(idx) < msb_pkg::NUM_STACKS) begin
         if (op == msb_pkg::OP_PUSH) begin
            slot = free_head;
            if (slot != msb_pkg::NULL_SLOT) begin
               free_head        = slot_next[slot];
               slot_next[slot]  = top_slot[idx];
               top_slot[idx]    = slot;
               slot_value[slot] = val;
               outcome.ok       = 1'b1;
            end
         end else begin
            slot = top_slot[idx];
            if (slot != msb_pkg::NULL_SLOT) begin
               outcome.value   = slot_value[slot];
               top_slot[idx]   = slot_next[slot];
               slot_next[slot] = free_head;
               free_head       = slot;
               outcome.ok      = 1'b1;
            end
         end
      end
      expected_outcomes.push_back(outcome);
   endfunction

   // compare a delivered response with the oldest prediction
   function void check_response(logic ok, logic [msb_pkg::DATA_W-1:0] value);
      stack_outcome_type outcome;
      if (expected_outcomes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: success %0b popped_value %0d",
                     ok, $signed(value));
         return;
      end
      outcome = expected_outcomes.pop_front();
      if (ok !== outcome.ok || value !== outcome.value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: success exp %0b got %0b, popped_value exp %0d got %0d",
                     outcome.ok, ok, $signed(outcome.value), $signed(value));
      end
   endfunction
endclass

module tb_multi_stack_shared_buffer_unit;
   import msb_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 850;
   localparam int unsigned CYCLE_LIMIT     = 400_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = OP_PUSH;
   logic [STACK_W-1:0]         req_stack_index = '0;
   logic signed [DATA_W-1:0]   req_push_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_success;
   logic signed [DATA_W-1:0]   rsp_popped_value;

   shared_stack_predictor      stack_shadow = new();
   int unsigned                cycle_count = 0;
   int unsigned                rsp_stall_left = 0;
   logic                       rsp_calm = 1'b0;

   multi_stack_shared_buffer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_stack_index  (req_stack_index),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_success      (rsp_success),
      .rsp_popped_value (rsp_popped_value)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // response side back-pressure, with calm stretches now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (cycle_count % 512 == 0)
            rsp_calm <= ($urandom_range(0, 3) == 0);
         if (rsp_stall_left != 0) begin
            rsp_ready      <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm)
               rsp_stall_left <= pick_gap();
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         stack_shadow.check_response(rsp_success, rsp_popped_value);
   end

   // present one request after an optional gap and wait for acceptance
   task automatic send_request(input logic op, input logic [STACK_W-1:0] idx,
                               input logic [DATA_W-1:0] val, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= op;
      req_stack_index <= idx;
      req_push_value  <= val;
      do @(posedge clock); while (!req_ready);
      stack_shadow.note_request(op, idx, val);
   endtask

   // hold off the sender until every predicted response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (stack_shadow.pending() != 0);
   endtask

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // main sequence
   initial begin
      logic [DATA_W-1:0]   corner_values [6];
      logic [STACK_W-1:0]  idx;
      logic [STACK_W-1:0]  focus_stack;
      logic [DATA_W-1:0]   val;
      logic                op;
      int unsigned         sent;
      int unsigned         burst_len;
      int unsigned         push_pct;
      int unsigned         gap;
      logic                focused;

      corner_values = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                        32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: pop on an empty stack, fill the store, push on a full
      // store, then pop the top of every stack
      send_request(OP_POP, STACK_W'(3), '0, 0);
      for (int i = 0; i < CAPACITY; i++) begin
         idx = (i < 8) ? '0 : STACK_W'(i % NUM_STACKS);
         val = (i < 6) ? corner_values[i] : $urandom();
         send_request(OP_PUSH, idx, val, pick_gap());
      end
      send_request(OP_PUSH, STACK_W'(1), 32'h1234_5678, 0);
      for (int i = 0; i < NUM_STACKS; i++)
         send_request(OP_POP, STACK_W'(i), $urandom(), pick_gap());
      wait_for_drain();

      // random bursts, each leaning towards pushes or pops
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst_len   = $urandom_range(10, 60);
         case ($urandom_range(0, 3))
            0:       push_pct = 15;
            1:       push_pct = 50;
            2:       push_pct = 85;
            default: push_pct = 95;
         endcase
         focused     = ($urandom_range(0, 1) == 1);
         focus_stack = STACK_W'($urandom_range(0, NUM_STACKS - 1));
         for (int j = 0; j < burst_len && sent < RANDOM_REQUESTS; j++) begin
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            idx = (focused && $urandom_range(0, 3) != 0) ? focus_stack
                                                         : STACK_W'($urandom_range(0, 3));
            val = ($urandom_range(0, 7) == 0) ? corner_values[$urandom_range(0, 5)]
                                              : $urandom();
            // a stretch with no sender gaps
            gap = (sent >= 300 && sent < 420) ? 0 : pick_gap();
            send_request(op, idx, val, gap);
            sent++;
         end
         if ($urandom_range(0, 5) == 0)
            wait_for_drain();
      end

      // let the pipeline empty, then allow for stray responses
      wait_for_drain();
      repeat (8) @(posedge clock);

      if (stack_shadow.mismatches == 0 && stack_shadow.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/msb_pkg.sv
rtl/msb_ctrl.sv
rtl/msb_datapath.sv
rtl/multi_stack_shared_buffer_unit.sv
tb/tb_multi_stack_shared_buffer_unit.sv
